// File: rtl/ecu_pkg.sv
// shared types and constants for the elevator cabin controller
// no dependencies; used by ecu_ctrl, ecu_datapath and elevator_controller_unit
package ecu_pkg;

    // defaults for top level parameters
    localparam int MAX_FLOORS_DEF = 16;
    localparam int TICK_WRAP_DEF  = 256;

    // fixed field widths
    localparam int MODE_W   = 3;
    localparam int CALL_W   = 4;
    localparam int STATE_W  = 3;
    localparam int DIR_W    = 2;
    localparam int FLOOR_OW = 4;
    localparam int MASK_OW  = 16;
    localparam int FCNT_W   = 5;
    localparam int PASS_W   = 8;
    localparam int CFG_A_W  = 1;
    localparam int CFG_D_W  = 8;
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 32;

    // input modes
    localparam logic [MODE_W-1:0] MODE_TICK        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CALL        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DOOR_OPENING = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DOOR_OPEN   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DOOR_CLOSING = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DOOR_CLOSED = 3'd5;

    // cabin states
    localparam logic [STATE_W-1:0] CAB_CLOSED  = 3'd0;
    localparam logic [STATE_W-1:0] CAB_OPEN    = 3'd1;
    localparam logic [STATE_W-1:0] CAB_MOVING  = 3'd2;
    localparam logic [STATE_W-1:0] CAB_OPENING = 3'd3;
    localparam logic [STATE_W-1:0] CAB_CLOSING = 3'd4;

    // travel directions
    localparam logic [DIR_W-1:0] DIR_IDLE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_FLOOR_COUNT = 1'd0;
    localparam logic [CFG_A_W-1:0] CFG_PASS_TICKS  = 1'd1;

    // configuration reset values
    localparam logic [FCNT_W-1:0] FLOOR_COUNT_RST = 5'd16;
    localparam logic [PASS_W-1:0] PASS_TICKS_RST  = 8'd10;

    // command from controller to datapath
    typedef struct packed {
        logic step;     // apply the accepted transaction and load the result
    } cmd_t;

endpackage

// File: rtl/ecu_ctrl.sv
// handshake controller for the elevator cabin controller
// depends on ecu_pkg; drives step commands into ecu_datapath
module ecu_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output ecu_pkg::cmd_t cmd
);

    localparam logic CTL_EMPTY = 1'b0;
    localparam logic CTL_FULL  = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    // result register frees up in the same cycle it is taken
    assign s_tready = (state_reg == CTL_EMPTY) || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == CTL_FULL);
    assign cmd.step = accept;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_EMPTY: begin
                if (accept) begin
                    state_next = CTL_FULL;
                end
            end
            CTL_FULL: begin
                if (!accept && m_tready) begin
                    state_next = CTL_EMPTY;
                end
            end
            default: state_next = CTL_EMPTY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/ecu_datapath.sv
// cabin state, request bits, configuration and result register
// depends on ecu_pkg; commanded by ecu_ctrl
module ecu_datapath #(
    parameter int MAX_FLOORS = ecu_pkg::MAX_FLOORS_DEF,
    parameter int TICK_WRAP  = ecu_pkg::TICK_WRAP_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ecu_pkg::cmd_t                   cmd,
    input  logic [ecu_pkg::MODE_W-1:0]      mode,
    input  logic [ecu_pkg::CALL_W-1:0]      call_floor,
    input  logic                            pressed,
    input  logic                            cfg_we,
    input  logic [ecu_pkg::CFG_A_W-1:0]     cfg_addr,
    input  logic [ecu_pkg::CFG_D_W-1:0]     cfg_wdata,
    output logic [ecu_pkg::STATE_W-1:0]     cabin_state,
    output logic [ecu_pkg::DIR_W-1:0]       travel_dir,
    output logic [ecu_pkg::FLOOR_OW-1:0]    current_floor,
    output logic                            floor_passed,
    output logic                            stop_pulse,
    output logic [ecu_pkg::MASK_OW-1:0]     pending_mask
);

    localparam int FLOOR_W = $clog2(MAX_FLOORS);
    localparam int FC_W    = $clog2(MAX_FLOORS + 1);
    localparam int CMP_W   = (FC_W > ecu_pkg::FCNT_W) ? FC_W : ecu_pkg::FCNT_W;
    localparam int TICK_W  = $clog2(TICK_WRAP);
    localparam int PT_W    = (TICK_W > ecu_pkg::PASS_W) ? TICK_W : ecu_pkg::PASS_W;
    localparam int FO_EXT  = (FLOOR_W > ecu_pkg::FLOOR_OW) ? FLOOR_W : ecu_pkg::FLOOR_OW;
    localparam int MK_EXT  = (MAX_FLOORS > ecu_pkg::MASK_OW) ? MAX_FLOORS : ecu_pkg::MASK_OW;

    // configuration
    logic [ecu_pkg::FCNT_W-1:0]  floor_count_reg;
    logic [ecu_pkg::PASS_W-1:0]  pass_ticks_reg;

    // cabin state
    logic [MAX_FLOORS-1:0]       req_reg,   req_next;
    logic [FLOOR_W-1:0]          floor_reg, floor_next;
    logic [ecu_pkg::STATE_W-1:0] cab_reg,   cab_next;
    logic [ecu_pkg::DIR_W-1:0]   dir_reg,   dir_next;
    logic [TICK_W-1:0]           tick_reg,  tick_next;

    // result register
    logic [ecu_pkg::STATE_W-1:0] out_cab_reg;
    logic [ecu_pkg::DIR_W-1:0]   out_dir_reg;
    logic [FLOOR_W-1:0]          out_floor_reg;
    logic                        out_passed_reg;
    logic                        out_stop_reg;
    logic [MAX_FLOORS-1:0]       out_req_reg;

    logic [CMP_W-1:0]            fc;
    logic [CMP_W-1:0]            fcount_ext;
    logic [CMP_W-1:0]            at_ext;
    logic [FLOOR_W-1:0]          at;
    logic [TICK_W-1:0]           tick_inc;
    logic [MAX_FLOORS-1:0]       above;
    logic [MAX_FLOORS-1:0]       below;
    logic                        any_above;
    logic                        any_below;
    logic                        can_up;
    logic                        can_down;
    logic                        passed;
    logic                        stop;
    logic [FO_EXT-1:0]           floor_ext_out;
    logic [MK_EXT-1:0]           mask_ext_out;

    // usable floor count, clamped to 1..MAX_FLOORS
    always_comb begin
        fcount_ext = CMP_W'(floor_count_reg);
        if (fcount_ext == '0) begin
            fc = CMP_W'(1);
        end else if (fcount_ext > CMP_W'(MAX_FLOORS)) begin
            fc = CMP_W'(MAX_FLOORS);
        end else begin
            fc = fcount_ext;
        end
    end

    assign tick_inc = (tick_reg == TICK_W'(TICK_WRAP - 1)) ? '0 : tick_reg + 1'b1;

    always_comb begin
        req_next   = req_reg;
        floor_next = floor_reg;
        cab_next   = cab_reg;
        dir_next   = dir_reg;
        tick_next  = tick_reg;
        passed     = 1'b0;
        stop       = 1'b0;
        can_up     = 1'b0;
        can_down   = 1'b0;
        above      = '0;
        below      = '0;
        any_above  = 1'b0;
        any_below  = 1'b0;
        at_ext     = CMP_W'(call_floor);
        if (at_ext >= fc) begin
            at_ext = fc - 1'b1;
        end
        at = at_ext[FLOOR_W-1:0];

        unique case (mode)
            ecu_pkg::MODE_TICK: begin
                tick_next = tick_inc;
                if (cab_reg == ecu_pkg::CAB_CLOSED && dir_reg != ecu_pkg::DIR_IDLE) begin
                    cab_next  = ecu_pkg::CAB_MOVING;
                    tick_next = '0;
                end
                if (cab_next == ecu_pkg::CAB_MOVING &&
                    PT_W'(tick_next) >= PT_W'(pass_ticks_reg)) begin
                    can_up   = (dir_reg == ecu_pkg::DIR_UP) &&
                               (CMP_W'(floor_reg) + 1'b1 < fc);
                    can_down = (dir_reg == ecu_pkg::DIR_DOWN) && (floor_reg != '0);
                    if (can_up || can_down) begin
                        tick_next  = '0;
                        floor_next = can_up ? floor_reg + 1'b1 : floor_reg - 1'b1;
                        passed     = 1'b1;
                        if (req_reg[floor_next]) begin
                            stop                 = 1'b1;
                            req_next[floor_next] = 1'b0;
                        end
                    end
                end
                // requests strictly above (within floor count) and strictly below
                for (int i = 0; i < MAX_FLOORS; i++) begin
                    above[i] = req_next[i] && (CMP_W'(i) < fc) &&
                               (CMP_W'(i) > CMP_W'(floor_next));
                    below[i] = req_next[i] && (CMP_W'(i) < CMP_W'(floor_next));
                end
                any_above = |above;
                any_below = |below;
                priority if (dir_reg == ecu_pkg::DIR_IDLE) begin
                    if (any_below) begin
                        dir_next = ecu_pkg::DIR_DOWN;
                    end else if (any_above) begin
                        dir_next = ecu_pkg::DIR_UP;
                    end
                end else if (dir_reg == ecu_pkg::DIR_UP) begin
                    if (!any_above && any_below) begin
                        dir_next = ecu_pkg::DIR_DOWN;
                    end
                end else if (dir_reg == ecu_pkg::DIR_DOWN) begin
                    if (any_above && !any_below) begin
                        dir_next = ecu_pkg::DIR_UP;
                    end
                end else begin
                    dir_next = dir_reg;
                end
                if (dir_next != ecu_pkg::DIR_IDLE && !any_above && !any_below) begin
                    dir_next = ecu_pkg::DIR_IDLE;
                end
            end
            ecu_pkg::MODE_CALL: begin
                if (at == floor_reg && cab_reg == ecu_pkg::CAB_CLOSED) begin
                    stop                = 1'b1;
                    tick_next           = '0;
                    req_next[floor_reg] = 1'b0;
                end else begin
                    req_next[at] = pressed;
                end
            end
            ecu_pkg::MODE_DOOR_OPENING: begin
                cab_next  = ecu_pkg::CAB_OPENING;
                tick_next = '0;
            end
            ecu_pkg::MODE_DOOR_OPEN: begin
                cab_next  = ecu_pkg::CAB_OPEN;
                tick_next = '0;
            end
            ecu_pkg::MODE_DOOR_CLOSING: begin
                cab_next  = ecu_pkg::CAB_CLOSING;
                tick_next = '0;
            end
            ecu_pkg::MODE_DOOR_CLOSED: begin
                cab_next  = ecu_pkg::CAB_CLOSED;
                tick_next = '0;
            end
            default: begin
                // unused modes leave the state alone
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_count_reg <= ecu_pkg::FLOOR_COUNT_RST;
            pass_ticks_reg  <= ecu_pkg::PASS_TICKS_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                ecu_pkg::CFG_FLOOR_COUNT: floor_count_reg <= cfg_wdata[ecu_pkg::FCNT_W-1:0];
                ecu_pkg::CFG_PASS_TICKS:  pass_ticks_reg  <= cfg_wdata[ecu_pkg::PASS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_reg   <= '0;
            floor_reg <= '0;
            cab_reg   <= ecu_pkg::CAB_CLOSED;
            dir_reg   <= ecu_pkg::DIR_IDLE;
            tick_reg  <= '0;
        end else if (cmd.step) begin
            req_reg   <= req_next;
            floor_reg <= floor_next;
            cab_reg   <= cab_next;
            dir_reg   <= dir_next;
            tick_reg  <= tick_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            out_cab_reg    <= cab_next;
            out_dir_reg    <= dir_next;
            out_floor_reg  <= floor_next;
            out_passed_reg <= passed;
            out_stop_reg   <= stop;
            out_req_reg    <= req_next;
        end
    end

    assign floor_ext_out = FO_EXT'(out_floor_reg);
    assign mask_ext_out  = MK_EXT'(out_req_reg);

    assign cabin_state   = out_cab_reg;
    assign travel_dir    = out_dir_reg;
    assign current_floor = floor_ext_out[ecu_pkg::FLOOR_OW-1:0];
    assign floor_passed  = out_passed_reg;
    assign stop_pulse    = out_stop_reg;
    assign pending_mask  = mask_ext_out[ecu_pkg::MASK_OW-1:0];

    // a stop always clears the request at the floor where the cabin stands
    a_stop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && stop |=> !req_reg[floor_reg])
        else $error("stop left the request of the current floor pending");

    // a floor pulse means the cabin really moved one floor
    a_pass_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && passed |=> floor_reg != $past(floor_reg))
        else $error("floor pulse without a floor change");

    // after a tick a direction is only kept while requests are pending
    a_dir_needs_req: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && mode == ecu_pkg::MODE_TICK |=>
            dir_reg == ecu_pkg::DIR_IDLE || req_reg != '0)
        else $error("direction set with no pending request");

endmodule

// File: rtl/elevator_controller_unit.sv
// top level of the elevator cabin controller
// depends on ecu_pkg, ecu_ctrl and ecu_datapath
//
// usage
//   s_ channel: one transaction per event. s_tuser carries the mode (tick, call,
//   or one of four door events); s_tdata carries the call floor and the pressed
//   flag. m_ channel: exactly one status transaction per accepted input.
//   cfg_ port: write floor_count (index 0) or pass_ticks (index 1) while the
//   block is idle; a write takes effect at the clock edge where cfg_we is high.
//   result: registered, it appears on m_ in the cycle after the input is accepted.
//   throughput: one transaction per cycle unless m_ stalls; the whole update
//   of the request bits, floor, cabin state and direction is one combinational
//   step between the state registers, and the result register is the only stage.
//   stall: while m_tready is low the result is held; a new input is still
//   taken as long as the result register is empty or being drained in the
//   same cycle.
//   reset (aresetn low, synchronous): no pending requests, floor 0, cabin
//   closed, direction idle, tick counter 0, floor_count 16, pass_ticks 10,
//   no result pending.
module elevator_controller_unit #(
    parameter int MAX_FLOORS = ecu_pkg::MAX_FLOORS_DEF,
    parameter int TICK_WRAP  = ecu_pkg::TICK_WRAP_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ecu_pkg::S_DATA_W-1:0]  s_tdata,   // call_floor[3:0], pressed[4], zero[7:5]
    input  logic [ecu_pkg::S_USER_W-1:0]  s_tuser,   // mode[2:0]
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // cabin_state[2:0], travel_dir[4:3], current_floor[8:5], floor_passed[9],
    // stop_pulse[10], pending_mask[26:11], zero[31:27]
    output logic [ecu_pkg::M_DATA_W-1:0]  m_tdata,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [ecu_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [ecu_pkg::CFG_D_W-1:0]   cfg_wdata
);

    ecu_pkg::cmd_t                   cmd;
    logic [ecu_pkg::STATE_W-1:0]     cabin_state;
    logic [ecu_pkg::DIR_W-1:0]       travel_dir;
    logic [ecu_pkg::FLOOR_OW-1:0]    current_floor;
    logic                            floor_passed;
    logic                            stop_pulse;
    logic [ecu_pkg::MASK_OW-1:0]     pending_mask;

    // handshake and result-register occupancy
    ecu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // cabin state update and result register
    ecu_datapath #(
        .MAX_FLOORS (MAX_FLOORS),
        .TICK_WRAP  (TICK_WRAP)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .mode          (s_tuser[ecu_pkg::MODE_W-1:0]),
        .call_floor    (s_tdata[ecu_pkg::CALL_W-1:0]),
        .pressed       (s_tdata[ecu_pkg::CALL_W]),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .cabin_state   (cabin_state),
        .travel_dir    (travel_dir),
        .current_floor (current_floor),
        .floor_passed  (floor_passed),
        .stop_pulse    (stop_pulse),
        .pending_mask  (pending_mask)
    );

    // pack the result fields, cabin_state in the lowest bits
    assign m_tdata = {5'b0, pending_mask, stop_pulse, floor_passed,
                      current_floor, travel_dir, cabin_state};

endmodule

// File: bench/ecu_checker.sv
`timescale 1ns / 1ps
// result checker for the elevator cabin controller: tracks cabin state from the
// accepted input transactions and compares every result transaction field by field
// depends on ecu_pkg
module ecu_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [ecu_pkg::S_DATA_W-1:0]  s_tdata,   // call_floor[3:0], pressed[4], zero[7:5]
    input  logic [ecu_pkg::S_USER_W-1:0]  s_tuser,   // mode[2:0]
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // cabin_state[2:0], travel_dir[4:3], current_floor[8:5], floor_passed[9],
    // stop_pulse[10], pending_mask[26:11], zero[31:27]
    input  logic [ecu_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          cfg_we,
    input  logic [ecu_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [ecu_pkg::CFG_D_W-1:0]   cfg_wdata,
    output int                            mismatches,
    output int                            outstanding,
    output int                            stops_seen,
    output int                            floors_seen
);

    // same bit order as m_tdata[26:0]
    typedef struct packed {
        logic [ecu_pkg::MASK_OW-1:0]  mask;
        logic                         stop;
        logic                         passed;
        logic [ecu_pkg::FLOOR_OW-1:0] floor;
        logic [ecu_pkg::DIR_W-1:0]    dir;
        logic [ecu_pkg::STATE_W-1:0]  cabin;
    } cabin_status_t;

    logic [ecu_pkg::FCNT_W-1:0]   floor_cfg;
    logic [ecu_pkg::PASS_W-1:0]   pass_cfg;
    logic [ecu_pkg::MASK_OW-1:0]  requests;
    logic [ecu_pkg::FLOOR_OW-1:0] floor_now;
    logic [ecu_pkg::STATE_W-1:0]  cabin;
    logic [ecu_pkg::DIR_W-1:0]    heading;
    int                           tick_cnt;
    cabin_status_t                status_q[$];
    int                           err_cnt;
    int                           result_no;
    int                           stop_cnt;
    int                           pass_cnt;

    function automatic int floors_in_use();
        if (floor_cfg == 0) return 1;
        if (floor_cfg > ecu_pkg::MAX_FLOORS_DEF) return ecu_pkg::MAX_FLOORS_DEF;
        return int'(floor_cfg);
    endfunction

    // one bit for every floor below n
    function automatic logic [ecu_pkg::MASK_OW-1:0] low_floors(int n);
        if (n >= ecu_pkg::MASK_OW) return '1;
        return (16'h1 << n) - 16'h1;
    endfunction

    // applies one transaction to the tracked cabin and returns the status it shows
    function automatic cabin_status_t next_cabin_status(logic [ecu_pkg::MODE_W-1:0] md,
                                                        logic [ecu_pkg::CALL_W-1:0] call_at,
                                                        logic press);
        cabin_status_t               st;
        int                          fc;
        int                          at;
        logic                        up_ok;
        logic                        down_ok;
        logic                        any_above;
        logic                        any_below;
        logic [ecu_pkg::MASK_OW-1:0] above;
        logic [ecu_pkg::MASK_OW-1:0] below;
        st = '0;
        fc = floors_in_use();
        case (md)
            ecu_pkg::MODE_TICK: begin
                tick_cnt++;
                if (tick_cnt >= ecu_pkg::TICK_WRAP_DEF) tick_cnt = 0;
                if (cabin == ecu_pkg::CAB_CLOSED && heading != ecu_pkg::DIR_IDLE) begin
                    cabin = ecu_pkg::CAB_MOVING;
                    tick_cnt = 0;
                end
                if (cabin == ecu_pkg::CAB_MOVING && tick_cnt >= int'(pass_cfg)) begin
                    up_ok = heading == ecu_pkg::DIR_UP && int'(floor_now) + 1 < fc;
                    down_ok = heading == ecu_pkg::DIR_DOWN && floor_now != 0;
                    if (up_ok || down_ok) begin
                        tick_cnt = 0;
                        floor_now = up_ok ? floor_now + 4'd1 : floor_now - 4'd1;
                        st.passed = 1'b1;
                        if (requests[floor_now]) begin
                            st.stop = 1'b1;
                            requests[floor_now] = 1'b0;
                        end
                    end
                end
                above = requests & low_floors(fc) & ~low_floors(int'(floor_now) + 1);
                below = requests & low_floors(int'(floor_now));
                any_above = above != 0;
                any_below = below != 0;
                case (heading)
                    ecu_pkg::DIR_IDLE: begin
                        if (any_below) heading = ecu_pkg::DIR_DOWN;
                        else if (any_above) heading = ecu_pkg::DIR_UP;
                    end
                    ecu_pkg::DIR_UP: begin
                        if (!any_above && any_below) heading = ecu_pkg::DIR_DOWN;
                    end
                    ecu_pkg::DIR_DOWN: begin
                        if (any_above && !any_below) heading = ecu_pkg::DIR_UP;
                    end
                    default: ;
                endcase
                if (heading != ecu_pkg::DIR_IDLE && !any_above && !any_below)
                    heading = ecu_pkg::DIR_IDLE;
            end
            ecu_pkg::MODE_CALL: begin
                at = int'(call_at);
                if (at >= fc) at = fc - 1;
                if (at == int'(floor_now) && cabin == ecu_pkg::CAB_CLOSED) begin
                    st.stop = 1'b1;
                    tick_cnt = 0;
                    requests[floor_now] = 1'b0;
                end else begin
                    requests[at] = press;
                end
            end
            ecu_pkg::MODE_DOOR_OPENING: begin
                cabin = ecu_pkg::CAB_OPENING;
                tick_cnt = 0;
            end
            ecu_pkg::MODE_DOOR_OPEN: begin
                cabin = ecu_pkg::CAB_OPEN;
                tick_cnt = 0;
            end
            ecu_pkg::MODE_DOOR_CLOSING: begin
                cabin = ecu_pkg::CAB_CLOSING;
                tick_cnt = 0;
            end
            ecu_pkg::MODE_DOOR_CLOSED: begin
                cabin = ecu_pkg::CAB_CLOSED;
                tick_cnt = 0;
            end
            default: ;
        endcase
        st.cabin = cabin;
        st.dir = heading;
        st.floor = floor_now;
        st.mask = requests;
        return st;
    endfunction

    task automatic check_field(input string name, input int want, input int seen);
        if (want != seen) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("result %0d, %s: expected %0d, got %0d", result_no, name, want, seen);
        end
    endtask

    always @(posedge aclk) begin
        cabin_status_t want;
        cabin_status_t seen;
        if (!aresetn) begin
            floor_cfg = ecu_pkg::FLOOR_COUNT_RST;
            pass_cfg = ecu_pkg::PASS_TICKS_RST;
            requests = '0;
            floor_now = '0;
            cabin = ecu_pkg::CAB_CLOSED;
            heading = ecu_pkg::DIR_IDLE;
            tick_cnt = 0;
            status_q.delete();
        end else begin
            // drain before queuing: a result never belongs to the same edge's input
            if (m_tvalid && m_tready) begin
                seen = cabin_status_t'(m_tdata[$bits(cabin_status_t)-1:0]);
                if (status_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("result %0d arrived with nothing expected: %h",
                                 result_no, m_tdata);
                end else begin
                    want = status_q.pop_front();
                    check_field("cabin_state", want.cabin, seen.cabin);
                    check_field("travel_dir", want.dir, seen.dir);
                    check_field("current_floor", want.floor, seen.floor);
                    check_field("floor_passed", want.passed, seen.passed);
                    check_field("stop_pulse", want.stop, seen.stop);
                    check_field("pending_mask", want.mask, seen.mask);
                    stop_cnt += want.stop;
                    pass_cnt += want.passed;
                end
                result_no++;
            end
            if (s_tvalid && s_tready)
                status_q.push_back(next_cabin_status(s_tuser,
                                                     s_tdata[ecu_pkg::CALL_W-1:0],
                                                     s_tdata[ecu_pkg::CALL_W]));
            if (cfg_we) begin
                if (cfg_addr == ecu_pkg::CFG_FLOOR_COUNT)
                    floor_cfg = cfg_wdata[ecu_pkg::FCNT_W-1:0];
                else if (cfg_addr == ecu_pkg::CFG_PASS_TICKS)
                    pass_cfg = cfg_wdata[ecu_pkg::PASS_W-1:0];
            end
        end
        mismatches <= err_cnt;
        outstanding <= status_q.size();
        stops_seen <= stop_cnt;
        floors_seen <= pass_cnt;
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// top of the elevator controller bench: clock, reset, stimulus and verdict
// depends on ecu_pkg, elevator_controller_unit and ecu_checker
module testbench;

    // modes the block must ignore
    localparam logic [ecu_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [ecu_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 64;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 100;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [ecu_pkg::S_DATA_W-1:0]  s_tdata;   // call_floor[3:0], pressed[4], zero[7:5]
    logic [ecu_pkg::S_USER_W-1:0]  s_tuser;   // mode[2:0]
    logic                          m_tvalid;
    logic                          m_tready;
    // cabin_state[2:0], travel_dir[4:3], current_floor[8:5], floor_passed[9],
    // stop_pulse[10], pending_mask[26:11], zero[31:27]
    logic [ecu_pkg::M_DATA_W-1:0]  m_tdata;
    logic                          cfg_we;
    logic [ecu_pkg::CFG_A_W-1:0]   cfg_addr;
    logic [ecu_pkg::CFG_D_W-1:0]   cfg_wdata;

    int   mismatches;
    int   outstanding;
    int   stops_seen;
    int   floors_seen;
    int   cycles = 0;
    int   items_sent = 0;
    int   settings_used = 0;
    logic stall_req = 1'b0;   // asks the receiver for one long hold-off
    logic no_idle = 1'b0;     // both sides run flat out while set

    elevator_controller_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    ecu_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .stops_seen  (stops_seen),
        .floors_seen (floors_seen)
    );

    // 10 ns clock, first rising edge at 5 ns
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // watchdog against a hung handshake
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected", cycles, outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // gap length for either side: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random back-pressure, plus the long hold-off on request
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            if (stall_req) begin
                stall_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    m_tready <= 1'b1;
                    @(posedge aclk);
                end else begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // offer one input transaction and hold it until the block takes it;
    // valid stays high between back-to-back transactions
    task automatic send_item(input logic [ecu_pkg::MODE_W-1:0] md,
                             input logic [ecu_pkg::CALL_W-1:0] fl,
                             input logic pr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= md;
        s_tdata <= {3'b000, pr, fl};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // stop offering and wait until every expected result has been taken
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // writes both registers back to back while the block is idle
    task automatic set_config(input logic [ecu_pkg::FCNT_W-1:0] fc,
                              input logic [ecu_pkg::PASS_W-1:0] pt);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_addr <= ecu_pkg::CFG_FLOOR_COUNT;
        cfg_wdata <= {3'b000, fc};
        @(posedge aclk);
        cfg_addr <= ecu_pkg::CFG_PASS_TICKS;
        cfg_wdata <= pt;
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // mostly ticks and calls, door cycles as complete sequences, a little noise
    task automatic send_random();
        int r;
        r = $urandom_range(0, 99);
        if (r < 58) begin
            send_item(ecu_pkg::MODE_TICK, ecu_pkg::CALL_W'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)));
        end else if (r < 80) begin
            send_item(ecu_pkg::MODE_CALL, ecu_pkg::CALL_W'($urandom_range(0, 15)),
                      $urandom_range(0, 3) != 0);
        end else if (r < 86) begin
            send_item(ecu_pkg::MODE_DOOR_CLOSED, '0, 1'b0);
        end else if (r < 94) begin
            // full door cycle so the cabin can move again afterwards
            send_item(ecu_pkg::MODE_DOOR_OPENING, '0, 1'b0);
            send_item(ecu_pkg::MODE_DOOR_OPEN, '0, 1'b0);
            send_item(ecu_pkg::MODE_DOOR_CLOSING, '0, 1'b0);
            send_item(ecu_pkg::MODE_DOOR_CLOSED, '0, 1'b0);
        end else if (r < 97) begin
            send_item(ecu_pkg::MODE_DOOR_CLOSING, ecu_pkg::CALL_W'($urandom_range(0, 15)),
                      1'b1);
        end else begin
            send_item($urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B,
                      ecu_pkg::CALL_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        logic [ecu_pkg::FCNT_W-1:0] fc;
        logic [ecu_pkg::PASS_W-1:0] pt;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset configuration: immediate stop at the cabin floor,
        // set and clear of the top floor, ignored modes, every door event
        send_item(ecu_pkg::MODE_CALL, 4'd0, 1'b1);
        send_item(ecu_pkg::MODE_CALL, 4'd15, 1'b1);
        send_item(ecu_pkg::MODE_CALL, 4'd15, 1'b0);
        send_item(MODE_SPARE_A, 4'd15, 1'b1);
        send_item(MODE_SPARE_B, 4'd0, 1'b0);
        send_item(ecu_pkg::MODE_DOOR_OPENING, 4'd0, 1'b0);
        send_item(ecu_pkg::MODE_DOOR_OPEN, 4'd0, 1'b0);
        send_item(ecu_pkg::MODE_DOOR_CLOSING, 4'd0, 1'b0);
        send_item(ecu_pkg::MODE_DOOR_CLOSED, 4'd0, 1'b0);

        // floor count above the maximum, a step on every tick
        set_config(5'd31, 8'd0);
        send_item(ecu_pkg::MODE_CALL, 4'd3, 1'b1);
        send_item(ecu_pkg::MODE_CALL, 4'd1, 1'b1);
        send_item(ecu_pkg::MODE_TICK, 4'd0, 1'b0);   // direction up
        send_item(ecu_pkg::MODE_TICK, 4'd0, 1'b0);   // starts moving, stops at floor 1
        send_item(ecu_pkg::MODE_TICK, 4'd0, 1'b0);   // floor 2

        // floor count shrunk under the pending request: step up blocked
        set_config(5'd3, 8'd0);
        send_item(ecu_pkg::MODE_TICK, 4'd0, 1'b0);
        send_item(ecu_pkg::MODE_CALL, 4'd0, 1'b1);
        send_item(ecu_pkg::MODE_TICK, 4'd0, 1'b0);   // idle while moving, turns down
        send_item(ecu_pkg::MODE_TICK, 4'd0, 1'b0);
        send_item(ecu_pkg::MODE_TICK, 4'd0, 1'b0);   // stop at floor 0

        // zero floor count acts as one: every call clamps to floor 0
        set_config(5'd0, 8'd255);
        send_item(ecu_pkg::MODE_CALL, 4'd9, 1'b1);
        send_item(ecu_pkg::MODE_DOOR_CLOSED, 4'd0, 1'b0);
        send_item(ecu_pkg::MODE_CALL, 4'd12, 1'b1);  // closed at floor 0: stops at once
        send_item(ecu_pkg::MODE_TICK, 4'd0, 1'b0);
        send_item(ecu_pkg::MODE_DOOR_OPEN, 4'd0, 1'b0);

        // random phases, one register setting each
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin fc = ecu_pkg::FLOOR_COUNT_RST; pt = ecu_pkg::PASS_TICKS_RST; end
                1: begin fc = 5'd1; pt = 8'd0; end
                2: begin fc = 5'd2; pt = 8'd1; end
                3: begin fc = 5'd31; pt = 8'd2; end
                4: begin
                    fc = ecu_pkg::FCNT_W'($urandom_range(3, 15));
                    pt = ecu_pkg::PASS_W'($urandom_range(0, 7));
                end
                5: begin fc = 5'd16; pt = 8'd255; end
                6: begin
                    fc = ecu_pkg::FCNT_W'($urandom_range(0, 31));
                    pt = ecu_pkg::PASS_W'($urandom_range(0, 255));
                end
                default: begin fc = ecu_pkg::FCNT_W'($urandom_range(17, 30)); pt = 8'd3; end
            endcase
            set_config(fc, pt);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // stretches with no idling on even phases
                no_idle = (ph % 2 == 0) && i < 25;
                if (ph == 2 && i == 40) begin
                    // receiver holds off while the sender keeps offering:
                    // the result register fills and the input stalls
                    stall_req = 1'b1;
                    no_idle = 1'b1;
                    repeat (16) send_random();
                    no_idle = 1'b0;
                end
                // sender pauses until everything has drained
                if (ph == 4 && i == 60) wait_idle();
                send_random();
            end
        end
        no_idle = 1'b0;

        wait_idle();
        repeat (4) @(posedge aclk);
        $display("%0d input transactions across %0d register settings", items_sent,
                 settings_used);
        $display("%0d floors passed and %0d stop requests checked", floors_seen, stops_seen);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
